>>> design/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared types and constants for the dense graph shortest path block.
// ----------------------------------------------------------------------------
package dgsp_pkg;

  localparam int MaxVertices = 256;
  localparam int VertBits    = 8;
  localparam int CountBits   = 9;
  localparam int WeightBits  = 24;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 24;
  localparam int InDataBits  = 40;
  localparam int OutDataBits = 48;

  localparam logic [CountBits-1:0]  CountReset = 9'd256;
  localparam logic [VertBits-1:0]   SourceReset = 8'd0;
  localparam logic [WeightBits-1:0] LimitReset = 24'd1000000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_COUNT  = 2'd0,
    CFG_SOURCE = 2'd1,
    CFG_LIMIT  = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_INIT,
    ST_SCAN,
    ST_RELAX,
    ST_DONE
  } state_t;

endpackage

>>> design/dgsp_ram.sv
// ----------------------------------------------------------------------------
// dgsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/dense_graph_shortest_path.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_path
// Single-source shortest paths over a 256 x 256 weight matrix held in RAM.
// ----------------------------------------------------------------------------
// Weight loads are written straight into the weight RAM; a vertex read is one
// RAM read followed by the output load. Settled flags live in a RAM: a clearing
// pass writes them all to zero after reset, when no request is taken, and at
// the start of every run request. The run then seeds the distances from the
// source row, then per settled vertex makes one scan pass and one relax pass,
// each reading the vertices one at a time through the single read port of the
// distance and weight RAMs.
module dense_graph_shortest_path (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row_index [7:0], column_index [15:8], edge_weight [39:16]
  input  logic [dgsp_pkg::InDataBits-1:0] s_tdata,
  // op [1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // vertex_id [7:0], path_length [31:8], previous_vertex [39:32],
  // settled [40], zero [47:41]
  output logic [dgsp_pkg::OutDataBits-1:0] m_tdata,
  // run_done [0]
  output logic                            m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dgsp_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [dgsp_pkg::CfgDataBits-1:0] cfg_data
);

  localparam int VB = dgsp_pkg::VertBits;
  localparam int CB = dgsp_pkg::CountBits;
  localparam int WB = dgsp_pkg::WeightBits;

  dgsp_pkg::state_t state, state_next;

  logic [CB-1:0] vertex_count;
  logic [VB-1:0] source_vertex;
  logic [WB-1:0] no_path_limit;

  logic [CB-1:0] n;
  logic [VB-1:0] src;
  logic [CB-1:0] left;
  logic [CB-1:0] cnt;
  logic          p_vld;
  logic [VB-1:0] p_idx;
  logic          found;
  logic [WB-1:0] best;
  logic [VB-1:0] pick;
  logic [VB-1:0] rd_row;
  logic          clr_run;

  logic          in_take;
  logic          out_free;
  dgsp_pkg::op_t in_op;
  logic [VB-1:0] in_row;
  logic [VB-1:0] in_col;
  logic [WB-1:0] in_weight;
  logic [CB-1:0] n_clamp;
  logic          issue;
  logic          pass_end;
  logic          clr_end;

  logic              w_we;
  logic [2*VB-1:0]   w_waddr;
  logic [2*VB-1:0]   w_raddr;
  logic [WB-1:0]     w_rdata;
  logic              d_we;
  logic [VB-1:0]     d_waddr;
  logic [WB-1:0]     d_wdata;
  logic [VB-1:0]     d_raddr;
  logic [WB-1:0]     d_rdata;
  logic [VB-1:0]     p_wdata;
  logic [VB-1:0]     p_rdata;
  logic              f_we;
  logic [VB-1:0]     f_waddr;
  logic              f_wdata;
  logic              f_rdata;
  logic [WB:0]       sum;
  logic [WB-1:0]     cand;
  logic              relax_hit;
  logic              scan_hit;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == dgsp_pkg::ST_IDLE) && out_free;
  assign in_take   = s_tvalid && s_tready;
  assign in_op     = dgsp_pkg::op_t'(s_tuser);
  assign in_row    = s_tdata[VB-1:0];
  assign in_col    = s_tdata[2*VB-1:VB];
  assign in_weight = s_tdata[2*VB+WB-1:2*VB];

  always_comb begin
    if (vertex_count == '0) begin
      n_clamp = CB'(1);
    end else if (vertex_count > CB'(dgsp_pkg::MaxVertices)) begin
      n_clamp = CB'(dgsp_pkg::MaxVertices);
    end else begin
      n_clamp = vertex_count;
    end
  end

  assign issue    = cnt < n;
  assign pass_end = !issue && !p_vld;
  assign clr_end  = (cnt == CB'(dgsp_pkg::MaxVertices - 1));

  assign sum       = {1'b0, best} + {1'b0, w_rdata};
  assign cand      = sum[WB] ? {WB{1'b1}} : sum[WB-1:0];
  assign relax_hit = p_vld && !f_rdata && (cand < d_rdata);
  assign scan_hit  = p_vld && !f_rdata && (d_rdata < no_path_limit) &&
                     (!found || d_rdata < best);

  // RAM ports
  assign w_we    = in_take && (in_op == dgsp_pkg::OP_LOAD);
  assign w_waddr = {in_row, in_col};
  assign w_raddr = (state == dgsp_pkg::ST_INIT) ? {src, cnt[VB-1:0]} : {pick, cnt[VB-1:0]};
  assign d_raddr = (state == dgsp_pkg::ST_IDLE) ? in_row : cnt[VB-1:0];
  assign d_waddr = p_idx;

  always_comb begin
    d_we    = 1'b0;
    d_wdata = w_rdata;
    p_wdata = src;
    if (state == dgsp_pkg::ST_INIT) begin
      d_we = p_vld;
    end else if (state == dgsp_pkg::ST_RELAX) begin
      d_we    = relax_hit;
      d_wdata = cand;
      p_wdata = pick;
    end
  end

  // settled flag writes
  always_comb begin
    f_we    = 1'b0;
    f_waddr = cnt[VB-1:0];
    f_wdata = 1'b0;
    if (state == dgsp_pkg::ST_CLEAR) begin
      f_we = 1'b1;
    end else if (state == dgsp_pkg::ST_INIT && pass_end) begin
      f_we    = 1'b1;
      f_waddr = src;
      f_wdata = 1'b1;
    end else if (state == dgsp_pkg::ST_SCAN && pass_end && found) begin
      f_we    = 1'b1;
      f_waddr = pick;
      f_wdata = 1'b1;
    end
  end

  dgsp_ram #(.WIDTH(WB), .DEPTH(dgsp_pkg::MaxVertices * dgsp_pkg::MaxVertices)) u_weight (
    .clk     (clk),
    .wr_en   (w_we),
    .wr_addr (w_waddr),
    .wr_data (in_weight),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  dgsp_ram #(.WIDTH(WB), .DEPTH(dgsp_pkg::MaxVertices)) u_dist (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (d_waddr),
    .wr_data (d_wdata),
    .rd_addr (d_raddr),
    .rd_data (d_rdata)
  );

  dgsp_ram #(.WIDTH(VB), .DEPTH(dgsp_pkg::MaxVertices)) u_pred (
    .clk     (clk),
    .wr_en   (d_we),
    .wr_addr (d_waddr),
    .wr_data (p_wdata),
    .rd_addr (d_raddr),
    .rd_data (p_rdata)
  );

  dgsp_ram #(.WIDTH(1), .DEPTH(dgsp_pkg::MaxVertices)) u_flag (
    .clk     (clk),
    .wr_en   (f_we),
    .wr_addr (f_waddr),
    .wr_data (f_wdata),
    .rd_addr (d_raddr),
    .rd_data (f_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dgsp_pkg::ST_IDLE: begin
        if (in_take) begin
          unique case (in_op)
            dgsp_pkg::OP_RUN:  state_next = dgsp_pkg::ST_CLEAR;
            dgsp_pkg::OP_READ: state_next = dgsp_pkg::ST_READ;
            dgsp_pkg::OP_LOAD,
            dgsp_pkg::OP_NONE: state_next = dgsp_pkg::ST_IDLE;
          endcase
        end
      end
      dgsp_pkg::ST_CLEAR: begin
        if (clr_end) begin
          if (!clr_run) begin
            state_next = dgsp_pkg::ST_IDLE;
          end else begin
            state_next = ({1'b0, src} < n) ? dgsp_pkg::ST_INIT : dgsp_pkg::ST_DONE;
          end
        end
      end
      dgsp_pkg::ST_READ: state_next = dgsp_pkg::ST_IDLE;
      dgsp_pkg::ST_INIT: begin
        if (pass_end) begin
          state_next = (left == '0) ? dgsp_pkg::ST_DONE : dgsp_pkg::ST_SCAN;
        end
      end
      dgsp_pkg::ST_SCAN: begin
        if (pass_end) begin
          state_next = found ? dgsp_pkg::ST_RELAX : dgsp_pkg::ST_DONE;
        end
      end
      dgsp_pkg::ST_RELAX: begin
        if (pass_end) begin
          state_next = (left == CB'(1)) ? dgsp_pkg::ST_DONE : dgsp_pkg::ST_SCAN;
        end
      end
      dgsp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = dgsp_pkg::ST_IDLE;
        end
      end
      default: state_next = dgsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgsp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= dgsp_pkg::CountReset;
      source_vertex <= dgsp_pkg::SourceReset;
      no_path_limit <= dgsp_pkg::LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dgsp_pkg::cfg_idx_t'(cfg_index))
        dgsp_pkg::CFG_COUNT:  vertex_count  <= cfg_data[CB-1:0];
        dgsp_pkg::CFG_SOURCE: source_vertex <= cfg_data[VB-1:0];
        dgsp_pkg::CFG_LIMIT:  no_path_limit <= cfg_data[WB-1:0];
        dgsp_pkg::CFG_SPARE:  ;
      endcase
    end
  end

  // pass counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      p_vld   <= 1'b0;
      found   <= 1'b0;
      clr_run <= 1'b0;
    end else begin
      p_vld <= 1'b0;
      if (in_take && in_op == dgsp_pkg::OP_RUN) begin
        clr_run <= 1'b1;
      end
      if (state == dgsp_pkg::ST_IDLE) begin
        cnt   <= '0;
        found <= 1'b0;
      end else if (state == dgsp_pkg::ST_CLEAR) begin
        cnt <= clr_end ? '0 : cnt + CB'(1);
      end else if (state == dgsp_pkg::ST_INIT || state == dgsp_pkg::ST_SCAN ||
                   state == dgsp_pkg::ST_RELAX) begin
        if (issue) begin
          cnt   <= cnt + CB'(1);
          p_vld <= 1'b1;
        end
        if (state == dgsp_pkg::ST_SCAN && scan_hit) begin
          found <= 1'b1;
        end
        if (pass_end) begin
          cnt <= '0;
          if (state != dgsp_pkg::ST_SCAN) begin
            found <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= cnt[VB-1:0];
    if (in_take) begin
      rd_row <= in_row;
      n      <= n_clamp;
      src    <= source_vertex;
      left   <= n_clamp - CB'(1);
    end
    if (state == dgsp_pkg::ST_SCAN && scan_hit) begin
      best <= d_rdata;
      pick <= p_idx;
    end
    if (state == dgsp_pkg::ST_RELAX && pass_end) begin
      left <= left - CB'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == dgsp_pkg::ST_READ || (state == dgsp_pkg::ST_DONE && out_free)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dgsp_pkg::ST_READ) begin
      m_tdata <= {7'd0, f_rdata, p_rdata, d_rdata, rd_row};
      m_tuser <= 1'b0;
    end else if (state == dgsp_pkg::ST_DONE && out_free) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
    end
  end

  a_relax_found: assert property (@(posedge clk) disable iff (rst)
    state == dgsp_pkg::ST_RELAX |-> found)
    else $error("relax pass without a chosen vertex");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    p_vld |-> ({1'b0, p_idx} < n))
    else $error("pass index beyond vertex count");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("completion result carries vertex data");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == dgsp_pkg::ST_IDLE && !p_vld))
    else $error("request taken while a run is active");

endmodule

>>> test/dense_graph_shortest_path_tb.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_path_tb
// Self-checking bench for the dense graph shortest path block: a directed
// table, then random small graphs with random stalls, every read and run
// completion compared with an in-bench path predictor.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path_tb;

  typedef struct packed {
    logic [7:0]  vid;
    logic [23:0] len;
    logic [7:0]  prev;
    logic        settled;
    logic        done;
  } path_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    dgsp_pkg::op_t   op;
    int              a;
    int              b;
    int              w;
    bit              typed;
    path_res_t       res;
  } plan_row_t;

  localparam int WatchLimit = 20000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [dgsp_pkg::InDataBits-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [dgsp_pkg::OutDataBits-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [dgsp_pkg::CfgIdxBits-1:0] cfg_index = '0;
  logic [dgsp_pkg::CfgDataBits-1:0] cfg_data = '0;

  dense_graph_shortest_path DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [23:0] wt_mem [0:65535];
  logic [23:0] len_mem [0:255];
  logic [7:0]  prev_mem [0:255];
  bit          settled_mem [0:255];
  bit          len_known [0:255];
  logic [8:0]  cfg_count = dgsp_pkg::CountReset;
  logic [7:0]  cfg_source = dgsp_pkg::SourceReset;
  logic [23:0] cfg_limit = dgsp_pkg::LimitReset;

  path_res_t expected_q [$];
  plan_row_t plan [$];
  int errors = 0;
  int idle_cycles = 0;
  int m_stall = 0;
  bit fast_mode = 0;

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int draw_gap();
    return fast_mode ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [23:0] sat_sum(logic [23:0] x, logic [23:0] y);
    logic [24:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  // keep v if its distance was written, else pick a written vertex
  function automatic int known_vertex(int v);
    int pool [$];
    if (v >= 0 && v < 256 && len_known[v]) return v;
    foreach (len_known[i]) if (len_known[i]) pool.push_back(i);
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic settle_paths();
    int n;
    int pick;
    bit found;
    logic [23:0] best;
    logic [23:0] cand;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > dgsp_pkg::MaxVertices) n = dgsp_pkg::MaxVertices;
    foreach (settled_mem[i]) settled_mem[i] = 0;
    if (cfg_source >= n) return;
    for (int i = 0; i < n; i++) begin
      len_mem[i] = wt_mem[{cfg_source, 8'(i)}];
      prev_mem[i] = cfg_source;
      len_known[i] = 1;
    end
    settled_mem[cfg_source] = 1;
    for (int left = n - 1; left > 0; left--) begin
      found = 0;
      best = 0;
      pick = 0;
      for (int i = 0; i < n; i++)
        if (!settled_mem[i] && len_mem[i] < cfg_limit && (!found || len_mem[i] < best)) begin
          found = 1;
          best = len_mem[i];
          pick = i;
        end
      if (!found) break;
      settled_mem[pick] = 1;
      for (int i = 0; i < n; i++) begin
        if (settled_mem[i]) continue;
        cand = sat_sum(best, wt_mem[{8'(pick), 8'(i)}]);
        if (cand < len_mem[i]) begin
          len_mem[i] = cand;
          prev_mem[i] = 8'(pick);
        end
      end
    end
  endtask

  task automatic predict(dgsp_pkg::op_t op, logic [7:0] r, logic [7:0] c, logic [23:0] w,
                         output bit has, output path_res_t res);
    has = 0;
    res = '0;
    case (op)
      dgsp_pkg::OP_LOAD: wt_mem[{r, c}] = w;
      dgsp_pkg::OP_RUN: begin
        settle_paths();
        has = 1;
        res.done = 1;
      end
      dgsp_pkg::OP_READ: begin
        has = 1;
        res.vid = r;
        res.len = len_mem[r];
        res.prev = prev_mem[r];
        res.settled = settled_mem[r];
      end
      default: ;
    endcase
  endtask

  task automatic send(dgsp_pkg::op_t op, int r, int c, int w, bit typed = 0,
                      path_res_t typed_res = '0);
    int gap;
    bit has;
    path_res_t res;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {w[23:0], c[7:0], r[7:0]};
    do @(posedge clk); while (!s_tready);
    predict(op, r[7:0], c[7:0], w[23:0], has, res);
    if (has) expected_q.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_reg(dgsp_pkg::cfg_idx_t idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      dgsp_pkg::CFG_COUNT:  cfg_count = val[8:0];
      dgsp_pkg::CFG_SOURCE: cfg_source = val[7:0];
      dgsp_pkg::CFG_LIMIT:  cfg_limit = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void add_row(row_kind_t k, dgsp_pkg::op_t op, int a, int b, int w,
                                  bit typed = 0);
    plan_row_t p;
    p.kind = k;
    p.op = op;
    p.a = a;
    p.b = b;
    p.w = w;
    p.typed = typed;
    p.res = '0;
    p.res.done = typed;
    plan.push_back(p);
  endfunction

  function automatic int draw_weight();
    int k;
    k = $urandom_range(0, 19);
    if (k < 4) return 0;
    if (k < 7) return 24'hFFFFFF;
    if (k < 10) return $urandom_range(0, 24'hFFFFFF);
    return $urandom_range(0, 20);
  endfunction

  // result side: check, stall, watchdog
  always @(posedge clk) begin
    path_res_t got;
    path_res_t want;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (!rst)
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("dense_graph_shortest_path test failed");
      $finish;
    end
    if (m_tvalid && m_tready) begin
      got.vid = m_tdata[7:0];
      got.len = m_tdata[31:8];
      got.prev = m_tdata[39:32];
      got.settled = m_tdata[40];
      got.done = m_tuser;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = expected_q.pop_front();
        if (got.vid !== want.vid)
          report($sformatf("vertex_id %h want %h", got.vid, want.vid));
        if (got.len !== want.len)
          report($sformatf("path_length %h want %h (v %0d)", got.len, want.len, want.vid));
        if (got.prev !== want.prev)
          report($sformatf("previous_vertex %h want %h (v %0d)", got.prev, want.prev, want.vid));
        if (got.settled !== want.settled)
          report($sformatf("settled %b want %b (v %0d)", got.settled, want.settled, want.vid));
        if (got.done !== want.done)
          report($sformatf("run_done %b want %b", got.done, want.done));
      end
      m_stall = draw_gap();
    end
    if (m_stall > 0) begin
      m_stall--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  initial begin
    int n;
    int rand_items;
    int order [$];
    foreach (len_known[i]) len_known[i] = 0;
    foreach (settled_mem[i]) settled_mem[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_COUNT, 0, 2);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_LIMIT, 0, 24'hFFFFFF);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 0, 0, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 0, 1, 5);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 1, 0, 24'hFFFFFF);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 1, 1, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_NONE, 255, 255, 24'hFFFFFF);
    add_row(ROW_ITEM, dgsp_pkg::OP_RUN, 0, 0, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 0, 0, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 1, 0, 0);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_SOURCE, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_RUN, 0, 0, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 0, 0, 0);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_SOURCE, 0, 2);
    add_row(ROW_ITEM, dgsp_pkg::OP_RUN, 0, 0, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 1, 0, 0);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_COUNT, 0, 0);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_SOURCE, 0, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_RUN, 0, 0, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 0, 0, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 1, 0, 0);
    add_row(ROW_CFG, dgsp_pkg::OP_NONE, dgsp_pkg::CFG_COUNT, 0, 3);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 0, 1, 24'hFFFFF0);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 0, 2, 24'hFFFFFF);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 1, 2, 24'hFFFFFF);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 2, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 2, 1, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_LOAD, 2, 2, 0);
    add_row(ROW_ITEM, dgsp_pkg::OP_RUN, 0, 0, 0, 1);
    add_row(ROW_ITEM, dgsp_pkg::OP_READ, 2, 0, 0);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        set_reg(dgsp_pkg::cfg_idx_t'(plan[i].a), plan[i].w);
      end else begin
        send(plan[i].op, plan[i].a, plan[i].b, plan[i].w, plan[i].typed, plan[i].res);
      end
    end

    // random small graphs
    rand_items = 0;
    while (rand_items < 370) begin
      wait_idle();
      fast_mode = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_reg(dgsp_pkg::CFG_COUNT, n);
      set_reg(dgsp_pkg::CFG_SOURCE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                    : $urandom_range(0, (n > 0) ? n - 1 : 0));
      case ($urandom_range(0, 3))
        0: set_reg(dgsp_pkg::CFG_LIMIT, 0);
        1: set_reg(dgsp_pkg::CFG_LIMIT, 24'hFFFFFF);
        2: set_reg(dgsp_pkg::CFG_LIMIT, dgsp_pkg::LimitReset);
        default: set_reg(dgsp_pkg::CFG_LIMIT, $urandom_range(0, 40));
      endcase
      if (n == 0) n = 1;
      order.delete();
      for (int k = 0; k < n * n; k++) order.push_back(k);
      order.shuffle();
      foreach (order[k]) begin
        send(dgsp_pkg::OP_LOAD, order[k] / n, order[k] % n, draw_weight());
        rand_items++;
        if ($urandom_range(0, 7) == 0) begin
          send($urandom_range(0, 1) ? dgsp_pkg::OP_NONE : dgsp_pkg::OP_LOAD,
               $urandom_range(0, 255), $urandom_range(0, 255), draw_weight());
          rand_items++;
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        send(dgsp_pkg::OP_READ, known_vertex($urandom_range(0, 255)), 0, 0);
        rand_items++;
      end
      send(dgsp_pkg::OP_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 24'hFFFFFF));
      rand_items++;
      for (int v = 0; v < n + 1; v++) begin
        send(dgsp_pkg::OP_READ, known_vertex((v < n) ? v : $urandom_range(0, 255)),
             $urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF));
        rand_items++;
      end
    end

    wait_idle();
    repeat (32) @(posedge clk);
    if (errors == 0) begin
      $display("dense_graph_shortest_path test passed");
    end else begin
      $display("dense_graph_shortest_path test failed");
    end
    $finish;
  end

endmodule
